### src/assert_macros.svh
// Assertion macros used by the radix converter RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Check that an expression holds at every clock edge outside reset
`define CHECK_ALWAYS(lbl, ck, rs, expr) \
  lbl: assert property (@(posedge ck) disable iff (rs) (expr)) \
    else $error("assertion failed");
// Check that a condition implies a consequence in the same cycle
`define CHECK_IMPLIES(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define CHECK_ALWAYS(lbl, ck, rs, expr)
`define CHECK_IMPLIES(lbl, ck, rs, ante, cons)
`endif

`endif

### src/rcu_pkg.sv
// Types, constants and helper functions for the radix converter
package rcu_pkg;

  localparam int MAX_DIGITS = 32;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int DIG_IDX_W  = $clog2(MAX_DIGITS);
  localparam int BASE_W     = 6;
  localparam int CHAR_W     = 8;
  localparam int CFG_IDX_W  = 2;

  localparam logic [BASE_W-1:0] BASE_MIN     = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX     = 6'd36;
  localparam logic [BASE_W-1:0] SOURCE_RESET = 6'd10;
  localparam logic [BASE_W-1:0] TARGET_RESET = 6'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE = 2'd0,
    REG_TARGET = 2'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BASE    = 2'd1,
    STAT_NODIGIT = 2'd2,
    STAT_OVF     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_DIV,
    S_EMIT,
    S_ERR
  } state_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    status_t           status;
    logic              last_digit;
  } out_item_t;

  typedef struct packed {
    logic              ok;
    logic [BASE_W-1:0] value;
  } char_info_t;

  function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
    logic [BASE_W-1:0] r;
    r = b;
    if (b < BASE_MIN) r = BASE_MIN;
    if (b > BASE_MAX) r = BASE_MAX;
    return r;
  endfunction

  function automatic char_info_t char_value(input logic [CHAR_W-1:0] c);
    char_info_t r;
    r.ok    = 1'b0;
    r.value = '0;
    case (c) inside
      [8'h30:8'h39]: begin
        r.ok    = 1'b1;
        r.value = BASE_W'(c - 8'h30);
      end
      [8'h61:8'h7a]: begin
        r.ok    = 1'b1;
        r.value = BASE_W'(c - 8'h57);
      end
      default: begin
        r.ok    = 1'b0;
        r.value = '0;
      end
    endcase
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [BASE_W-1:0] d);
    logic [CHAR_W-1:0] r;
    if (d < 6'd10) r = 8'h30 + CHAR_W'(d);
    else r = 8'h57 + CHAR_W'(d);
    return r;
  endfunction

endpackage

### src/radix_converter_unit.sv
// Radix converter top level: digit accumulation, serial division and digit output
`include "assert_macros.svh"

// Radix converter. Digit characters of a number arrive one item at a time,
// most significant first, the final one marked by last; each is folded into
// a running value with one multiply-add. A non-final character is accepted
// and then accumulated. On the final character the value is divided
// by the target base with a shared restoring divider that retires one
// quotient bit per cycle, and runs once for each output digit; the digits are
// then sent most significant first, one per cycle while the output is not
// stalled. A final character holds the input stalled until its last result
// item is loaded into the output register. Errors (digit not below the
// base, not a digit, overflow) give a single item with digit_char zero and
// the status code. The output register lets the next number start while
// the last result item still waits to be taken.
module radix_converter_unit #(
  parameter int VALUE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rcu_pkg::in_item_t                   in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rcu_pkg::out_item_t                  out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rcu_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rcu_pkg::BASE_W-1:0]          cfg_data
);
  import rcu_pkg::*;

  localparam int WIDE_W = VALUE_BITS + BASE_W + 1;
  localparam int BC_W   = $clog2(VALUE_BITS);

  state_t state, state_next;

  logic [BASE_W-1:0]     sbase, tbase;
  logic [CHAR_W-1:0]     ch_code;
  logic                  ch_last;
  logic [VALUE_BITS-1:0] accum;
  status_t               err;
  logic [VALUE_BITS-1:0] dv;
  logic [BASE_W-1:0]     rem;
  logic [BC_W-1:0]       bit_cnt;
  logic [CNT_W-1:0]      digit_count;
  logic [DIG_IDX_W-1:0]  rd_idx;
  logic [BASE_W-1:0]     store [MAX_DIGITS];

  char_info_t            cinfo;
  logic [WIDE_W-1:0]     wide;
  status_t               err_acc;
  logic [BASE_W:0]       rem_sh;
  logic                  q_bit;
  logic [BASE_W-1:0]     rem_new;
  logic [VALUE_BITS-1:0] dv_new;
  logic                  div_done;
  logic [CNT_W-1:0]      cnt_inc;
  logic                  out_free;
  logic                  out_load;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = out_free && (state == S_EMIT || state == S_ERR);

  // Accumulate datapath
  assign cinfo = char_value(ch_code);
  assign wide  = WIDE_W'(accum) * WIDE_W'(sbase) + WIDE_W'(cinfo.value);

  always_comb begin
    err_acc = err;
    if (err == STAT_OK) begin
      if (!cinfo.ok) err_acc = STAT_NODIGIT;
      else if (cinfo.value >= sbase) err_acc = STAT_BASE;
      else if (wide[WIDE_W-1:VALUE_BITS] != '0) err_acc = STAT_OVF;
    end
  end

  // One restoring-division step
  assign rem_sh   = {rem, dv[VALUE_BITS-1]};
  assign q_bit    = (rem_sh >= {1'b0, tbase});
  assign rem_new  = q_bit ? BASE_W'(rem_sh - {1'b0, tbase}) : BASE_W'(rem_sh);
  assign dv_new   = {dv[VALUE_BITS-2:0], q_bit};
  assign div_done = (bit_cnt == BC_W'(VALUE_BITS - 1));
  assign cnt_inc  = digit_count + CNT_W'(1);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_ACC;
      end
      S_ACC: begin
        if (!ch_last) state_next = S_IDLE;
        else if (err_acc != STAT_OK) state_next = S_ERR;
        else state_next = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          if (dv_new == '0) state_next = S_EMIT;
          else if (cnt_inc == CNT_W'(MAX_DIGITS)) state_next = S_ERR;
        end
      end
      S_EMIT: begin
        if (out_free && rd_idx == '0) state_next = S_IDLE;
      end
      S_ERR: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sbase       <= SOURCE_RESET;
      tbase       <= TARGET_RESET;
      accum       <= '0;
      err         <= STAT_OK;
      digit_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_SOURCE: sbase <= clamp_base(cfg_data);
          REG_TARGET: tbase <= clamp_base(cfg_data);
          default: ;
        endcase
      end

      // load a new item, or drop the one just taken
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            ch_code <= in_item.char_code;
            ch_last <= in_item.last;
          end
        end
        S_ACC: begin
          err <= err_acc;
          if (err == STAT_OK && err_acc == STAT_OK) accum <= wide[VALUE_BITS-1:0];
          if (ch_last && err_acc == STAT_OK) begin
            dv          <= wide[VALUE_BITS-1:0];
            rem         <= '0;
            bit_cnt     <= '0;
            digit_count <= '0;
          end
        end
        S_DIV: begin
          if (div_done) begin
            store[digit_count[DIG_IDX_W-1:0]] <= rem_new;
            digit_count <= cnt_inc;
            rd_idx      <= digit_count[DIG_IDX_W-1:0];
            dv          <= dv_new;
            rem         <= '0;
            bit_cnt     <= '0;
            if (dv_new != '0 && cnt_inc == CNT_W'(MAX_DIGITS)) err <= STAT_OVF;
          end else begin
            dv      <= dv_new;
            rem     <= rem_new;
            bit_cnt <= bit_cnt + BC_W'(1);
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_item.digit_char <= digit_ascii(store[rd_idx]);
            out_item.status     <= STAT_OK;
            out_item.last_digit <= (rd_idx == '0);
            if (rd_idx == '0) begin
              accum       <= '0;
              err         <= STAT_OK;
              digit_count <= '0;
            end else begin
              rd_idx <= rd_idx - DIG_IDX_W'(1);
            end
          end
        end
        S_ERR: begin
          if (out_free) begin
            out_item.digit_char <= '0;
            out_item.status     <= err;
            out_item.last_digit <= 1'b1;
            accum               <= '0;
            err                 <= STAT_OK;
            digit_count         <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  `CHECK_IMPLIES(a_err_single, clk, rst, out_valid && out_item.status != STAT_OK, out_item.last_digit && out_item.digit_char == '0)
  `CHECK_ALWAYS(a_count_bound, clk, rst, digit_count <= CNT_W'(MAX_DIGITS))
  `CHECK_IMPLIES(a_rem_bound, clk, rst, state == S_DIV, rem < tbase)
  `CHECK_IMPLIES(a_idle_clear, clk, rst, state == S_IDLE, digit_count == '0)

endmodule
